// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m: label");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== rtl/core/fgatn_pkg.sv =====
// Package for the filtered group aggregate block: payload types, states, register codes.
// No dependencies.
package fgatn_pkg;
  localparam int TableEntries = 32;
  localparam int SlotW = $clog2(TableEntries);
  localparam int CntW = $clog2(TableEntries + 1);
  localparam int MaxOut = 32;

  localparam logic [1:0] REG_CURRENT_TIME = 2'd0;
  localparam logic [1:0] REG_MIN_AGE      = 2'd1;
  localparam logic [1:0] REG_SIZE_FLOOR   = 2'd2;
  localparam logic [1:0] REG_REPORT_LIMIT = 2'd3;

  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] group_key;
    logic [63:0]        alloc_size;
    logic [63:0]        alloc_time;
  } in_item_t;

  typedef struct packed {
    logic               has_group;
    logic [4:0]         rank;
    logic signed [31:0] out_key;
    logic [63:0]        out_bytes;
    logic [31:0]        out_count;
    logic [63:0]        out_oldest;
    logic [5:0]         groups_total;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SEARCH, ST_SCAN, ST_FETCH, ST_EMIT
  } state_t;
endpackage

// ===== rtl/core/filtered_group_aggregate_top_n_unit.sv =====
// Filtered group aggregate with ranked top-N report: top level.
// Depends on fgatn_pkg and assert_macros.svh.
// Record: one slot compared per cycle; the next beat is taken once the search ends.
// Report: each beat is found by a scan, read in fetch and held in emit; the next scan
// waits for that beat's delivery, so output stall holds it; empty table gives one marker.
// Input stalls while busy. Sync reset: idle, empty table, registers to defaults (limit 32).
`include "assert_macros.svh"
module filtered_group_aggregate_top_n_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  fgatn_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output fgatn_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [63:0]          cfg_wdata
);
  import fgatn_pkg::*;

  logic [63:0] current_time, min_age, size_floor;
  logic [5:0]  report_limit;

  // slot store; only slots below slots_used are ever used
  logic [31:0] slot_key    [TableEntries];
  logic [63:0] slot_bytes  [TableEntries];
  logic [31:0] slot_count  [TableEntries];
  logic [63:0] slot_oldest [TableEntries];
  logic [TableEntries-1:0] taken;
  logic [CntW-1:0] slots_used;

  state_t state, state_next;
  in_item_t item;
  logic [CntW-1:0] idx;       // scan index
  logic [SlotW-1:0] best;
  logic [63:0] best_bytes;
  logic have;
  logic [CntW-1:0] rank, shown;
  out_item_t obuf;
  logic ovalid;

  // one read port into the store, address chosen by state
  logic [SlotW-1:0] raddr;
  assign raddr = (state == ST_FETCH) ? best : idx[SlotW-1:0];
  logic [31:0] rd_key;
  logic [63:0] rd_bytes;
  assign rd_key   = slot_key[raddr];
  assign rd_bytes = slot_bytes[raddr];

  logic [64:0] sum;
  assign sum = {1'b0, rd_bytes} + {1'b0, item.alloc_size};

  logic [5:0] lim;
  always_comb begin
    lim = report_limit;
    if (lim == 6'd0) lim = 6'd1;
    if (lim > 6'(MaxOut)) lim = 6'(MaxOut);
  end

  logic keep;
  assign keep = (current_time > item.alloc_time) &&
                ((current_time - item.alloc_time) >= min_age) &&
                (item.alloc_size >= size_floor);

  logic scan_done;
  assign scan_done = (idx == slots_used);

  assign in_stall  = (state != ST_IDLE) || ovalid;
  assign out_valid = ovalid;
  assign out_data  = obuf;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid && !in_stall) begin
        state_next = (in_data.opcode == OP_REPORT) ? ST_SCAN : ST_SEARCH;
      end
      ST_SEARCH: if (!keep || scan_done || rd_key == item.group_key) begin
        state_next = ST_IDLE;
      end
      ST_SCAN:   if (slots_used == '0 || scan_done) begin
        state_next = (slots_used == '0) ? ST_EMIT : ST_FETCH;
      end
      ST_FETCH:  state_next = ST_EMIT;
      ST_EMIT:   if (!ovalid) begin
        state_next = (slots_used == '0 || rank == shown) ? ST_IDLE : ST_SCAN;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_time <= '0;
      min_age      <= '0;
      size_floor   <= '0;
      report_limit <= 6'd32;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CURRENT_TIME: current_time <= cfg_wdata;
        REG_MIN_AGE:      min_age      <= cfg_wdata;
        REG_SIZE_FLOOR:   size_floor   <= cfg_wdata;
        REG_REPORT_LIMIT: report_limit <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slots_used <= '0;
      ovalid     <= 1'b0;
      idx        <= '0;
      rank       <= '0;
      taken      <= '0;
      have       <= 1'b0;
    end else begin
      state <= state_next;
      if (ovalid && !out_stall) ovalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid && !in_stall) begin
            item  <= in_data;
            idx   <= '0;
            rank  <= '0;
            have  <= 1'b0;
            taken <= '0;
            shown <= (slots_used < CntW'(lim)) ? slots_used : CntW'(lim);
          end
        end
        ST_SEARCH: begin
          if (keep) begin
            if (!scan_done && rd_key == item.group_key) begin
              slot_bytes[raddr] <= sum[64] ? '1 : sum[63:0];
              if (slot_count[raddr] != '1) slot_count[raddr] <= slot_count[raddr] + 32'd1;
              if ((current_time - item.alloc_time) > slot_oldest[raddr])
                slot_oldest[raddr] <= current_time - item.alloc_time;
            end else if (scan_done) begin
              if (slots_used < CntW'(TableEntries)) begin
                slot_key[slots_used[SlotW-1:0]]    <= item.group_key;
                slot_bytes[slots_used[SlotW-1:0]]  <= item.alloc_size;
                slot_count[slots_used[SlotW-1:0]]  <= 32'd1;
                slot_oldest[slots_used[SlotW-1:0]] <= current_time - item.alloc_time;
                slots_used <= slots_used + 1'b1;
              end
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (!scan_done) begin
            if (!taken[idx[SlotW-1:0]] && (!have || rd_bytes > best_bytes)) begin
              best       <= idx[SlotW-1:0];
              best_bytes <= rd_bytes;
              have       <= 1'b1;
            end
            idx <= idx + 1'b1;
          end
        end
        ST_FETCH: begin
          obuf.has_group    <= 1'b1;
          obuf.rank         <= rank[4:0];
          obuf.out_key      <= rd_key;
          obuf.out_bytes    <= rd_bytes;
          obuf.out_count    <= slot_count[raddr];
          obuf.out_oldest   <= slot_oldest[raddr];
          obuf.groups_total <= 6'(slots_used);
          obuf.last         <= (rank + 1'b1 == shown);
          taken[best]       <= 1'b1;
          rank              <= rank + 1'b1;
          ovalid            <= 1'b1;
        end
        ST_EMIT: begin
          if (slots_used == '0 && rank == '0 && !ovalid) begin
            obuf   <= '{last: 1'b1, default: '0};
            ovalid <= 1'b1;
            rank   <= CntW'(1);
          end
          idx  <= '0;
          have <= 1'b0;
          if (!ovalid && state_next == ST_IDLE) begin
            slots_used <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // empty marker: EMIT issues it and returns to idle; input stays stalled until delivery
  `ASSERT_NEVER(a_used_bound, clk, rst, slots_used > CntW'(TableEntries))
  `ASSERT_IMPL(a_busy_stall, clk, rst, (state != ST_IDLE) |-> in_stall)
  `ASSERT_IMPL(a_fetch_out, clk, rst, (state == ST_FETCH) |=> out_valid)
endmodule

// ===== sim/tb_filtered_group_aggregate_top_n_unit.sv =====
// Testbench for filtered_group_aggregate_top_n_unit: random and directed records and
// reports, checked against a behavioral model of the group table kept in a scoreboard class.
// Depends on fgatn_pkg and the top-level RTL.
module tb_filtered_group_aggregate_top_n_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import fgatn_pkg::*;

  // Behavioral group table plus queue of expected report beats.
  class group_table_sb;
    logic [63:0] now_ns, age_floor, size_floor;
    logic [5:0]  rpt_limit;
    logic [31:0] keys[TableEntries];
    logic [63:0] bytes_sum[TableEntries];
    logic [31:0] rec_cnt[TableEntries];
    logic [63:0] max_age[TableEntries];
    int          used;
    out_item_t   pending[$];
    int          errors;

    function new();
      now_ns = 0; age_floor = 0; size_floor = 0; rpt_limit = 32;
      used = 0; errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] v);
      case (idx)
        REG_CURRENT_TIME: now_ns = v;
        REG_MIN_AGE:      age_floor = v;
        REG_SIZE_FLOOR:   size_floor = v;
        REG_REPORT_LIMIT: rpt_limit = v[5:0];
        default: ;
      endcase
    endfunction

    function void merge_record(in_item_t it);
      logic [63:0] age;
      logic [64:0] sum;
      if (!(now_ns > it.alloc_time)) return;
      age = now_ns - it.alloc_time;
      if (age < age_floor || it.alloc_size < size_floor) return;
      for (int i = 0; i < used; i++) begin
        if (keys[i] == it.group_key) begin
          sum = {1'b0, bytes_sum[i]} + {1'b0, it.alloc_size};
          bytes_sum[i] = sum[64] ? '1 : sum[63:0];
          if (rec_cnt[i] != '1) rec_cnt[i]++;
          if (age > max_age[i]) max_age[i] = age;
          return;
        end
      end
      if (used < TableEntries) begin
        keys[used] = it.group_key; bytes_sum[used] = it.alloc_size;
        rec_cnt[used] = 1; max_age[used] = age; used++;
      end
    endfunction

    function void rank_groups();
      bit        taken[TableEntries];
      int        lim, shown, best;
      out_item_t o;
      if (used == 0) begin
        o = '0; o.last = 1'b1; pending.push_back(o); return;
      end
      lim = (rpt_limit == 0) ? 1 : ((rpt_limit > MaxOut) ? MaxOut : rpt_limit);
      shown = (used < lim) ? used : lim;
      foreach (taken[i]) taken[i] = 0;
      for (int r = 0; r < shown; r++) begin
        best = -1;
        for (int i = 0; i < used; i++)
          if (!taken[i] && (best < 0 || bytes_sum[i] > bytes_sum[best])) best = i;
        taken[best] = 1;
        o.has_group = 1'b1; o.rank = r[4:0]; o.out_key = keys[best];
        o.out_bytes = bytes_sum[best]; o.out_count = rec_cnt[best];
        o.out_oldest = max_age[best]; o.groups_total = used[5:0];
        o.last = (r + 1 == shown);
        pending.push_back(o);
      end
      used = 0;
    endfunction

    function void note_input(in_item_t it);
      if (it.opcode == OP_RECORD) merge_record(it);
      else rank_groups();
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected beat: %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        in_valid = 0, out_stall = 0, cfg_we = 0;
  logic        in_stall, out_valid;
  in_item_t    in_data = '0;
  out_item_t   out_data;
  logic [1:0]  cfg_index = REG_CURRENT_TIME;
  logic [63:0] cfg_wdata = '0;

  group_table_sb sb = new();
  bit  quiet = 0;       // last part of the run: no idling on either side
  int  hold_off = 0;    // long receiver stall requested by the stimulus
  longint cycles = 0;

  filtered_group_aggregate_top_n_unit DUT (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Watchdog: fails the run once the cycle count passes its limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output monitor: sample beats at the edge, before any NBA from this step lands.
  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off > 0) begin
        n = hold_off;
        hold_off = 0;
        out_stall <= 1;
        repeat (n) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // Send one beat; hold it until accepted. Valid is low on entry.
  task automatic send_beat(in_item_t it);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [63:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  // Idle point for register writes: nothing pending, then a wait for the last record to finish.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_item_t record(logic [31:0] k, logic [63:0] sz, logic [63:0] t);
    in_item_t it;
    it.opcode = OP_RECORD; it.group_key = k; it.alloc_size = sz; it.alloc_time = t;
    return it;
  endfunction

  function automatic in_item_t report_item();
    in_item_t it;
    it.opcode = OP_REPORT;
    it.group_key = $urandom; it.alloc_size = {$urandom, $urandom};
    it.alloc_time = {$urandom, $urandom};
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return '1 - $urandom_range(0, 3);
      2: return $urandom_range(0, 3);
      default: return {$urandom_range(0, 1), $urandom};
    endcase
  endfunction

  initial begin
    logic [31:0] key_pool[8];
    int nrec;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: empty report under reset config, then extremes.
    send_beat(report_item());
    drain();
    write_reg(REG_CURRENT_TIME, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_MIN_AGE, 64'd0);
    write_reg(REG_SIZE_FLOOR, 64'd0);
    write_reg(REG_REPORT_LIMIT, 6'd0);       // limit zero acts as one
    send_beat(record(32'h8000_0000, '1, 64'd0));
    send_beat(record(32'h8000_0000, 64'd5, 64'd1));       // bytes saturate
    send_beat(record(32'h7FFF_FFFF, 64'd0, '1));          // equal time: dropped
    send_beat(record(32'h7FFF_FFFF, 64'd7, 64'hFFFF_FFFF_FFFF_FFFE));
    send_beat(record(32'h0, 64'd7, 64'd3));               // tie with prior slot
    send_beat(report_item());
    drain();
    write_reg(REG_REPORT_LIMIT, 6'd63);       // above 32 saturates
    write_reg(REG_CURRENT_TIME, 64'd1000);
    write_reg(REG_MIN_AGE, 64'd100);
    write_reg(REG_SIZE_FLOOR, 64'd10);
    send_beat(record(32'd1, 64'd9, 64'd0));               // too small
    send_beat(record(32'd1, 64'd10, 64'd901));            // too young
    send_beat(record(32'd1, 64'd10, 64'd900));            // both at bound: kept
    send_beat(record(32'd1, 64'd50, 64'd2000));           // future: dropped
    // Fill the table past capacity: key 1 plus 33 new keys, the last two dropped.
    for (int i = 0; i < 33; i++) send_beat(record(32'd100 + i, 64'd10 + i, 64'd0));
    hold_off = 300;                           // long receiver stall during the report
    send_beat(report_item());
    send_beat(record(32'd5, 64'd20, 64'd0));
    send_beat(report_item());
    drain();

    // Random phases over several configurations.
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_CURRENT_TIME, (ph == 5) ? '1 : 64'd1 << (20 + ph * 7));
      write_reg(REG_MIN_AGE, (ph % 2) ? 64'd0 : ({$urandom} % 64'd1000));
      write_reg(REG_SIZE_FLOOR, (ph == 3) ? 64'hFFFF_FFFF_FFFF_FFF0 : {$urandom_range(0, 50)});
      write_reg(REG_REPORT_LIMIT, (ph == 4) ? 6'd1 : $urandom_range(0, 63));
      foreach (key_pool[i]) key_pool[i] = (i == 0) ? 32'hFFFF_FFFF : $urandom;
      if (ph == 5) quiet = 1;
      for (int b = 0; b < 4; b++) begin
        nrec = $urandom_range(1, 6);
        for (int r = 0; r < nrec; r++) begin
          if ($urandom_range(0, 9) == 0)
            send_beat(record($urandom, rand64(), rand64()));
          else
            send_beat(record(key_pool[$urandom_range(0, 7)],
                             (ph == 3) ? rand64() : {$urandom_range(0, 2000)},
                             sb.now_ns - $urandom_range(0, 5000)));
        end
        send_beat(report_item());
      end
      drain();
    end

    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
